FILE: rtl/core/rrmau_pkg.sv
// ----------------------------------------------------------------------------
// rrmau_pkg
// Shared types, codes and window-decode helpers of the RAM/ROM access unit.
// ----------------------------------------------------------------------------
package rrmau_pkg;

  localparam int unsigned RAM_BYTES_DEF = 65536;
  localparam int unsigned ROM_BYTES_DEF = 65536;
  localparam logic [31:0] RAM_BASE_DEF  = 32'h8000_0070;
  localparam logic [31:0] ROM_TOP_DEF   = 32'h7FFF_FFFF;

  // Byte offsets and indexes into either store never exceed 24 bits.
  localparam int unsigned OFF_W = 24;
  localparam int unsigned LEN_W = 17;

  localparam logic [31:0] BAD_WORD = 32'hC0DE_DBAD;

  typedef enum logic [3:0] {
    OP_RDBYTE  = 4'd0,
    OP_FETCH   = 4'd1,
    OP_WRBYTE  = 4'd2,
    OP_RDWORD  = 4'd3,
    OP_WRWORD  = 4'd4,
    OP_COPY    = 4'd5,
    OP_TAKECYC = 4'd6,
    OP_LEGAL   = 4'd7,
    OP_ROMLOAD = 4'd8
  } rrmau_op_e;

  typedef enum logic [1:0] {
    VIOL_NONE      = 2'd0,
    VIOL_READ      = 2'd1,
    VIOL_ROM_WRITE = 2'd2,
    VIOL_WRITE     = 2'd3
  } rrmau_viol_e;

  typedef enum logic [1:0] {
    REG_RAM_SIZE    = 2'd0,
    REG_ROM_PRESENT = 2'd1,
    REG_ROM_SIZE    = 2'd2,
    REG_TERMINATE   = 2'd3
  } rrmau_reg_e;

  typedef struct packed {
    logic [LEN_W-1:0] ram_size;
    logic             rom_present;
    logic [LEN_W-1:0] rom_size;
    logic             term_en;
  } rrmau_cfg_t;

  // A classified request as it travels from the front end to the back end.
  typedef struct packed {
    logic [3:0]       op;
    logic [31:0]      addr;
    logic [31:0]      wdata;
    logic [31:0]      daddr;
    logic [LEN_W-1:0] len;
    logic             ram1;
    logic             ram4;
    logic             rom1;
    logic             rom4;
    logic [OFF_W-1:0] ram_off;
    logic [OFF_W-1:0] rom_idx;
  } rrmau_cmd_t;

  function automatic logic [31:0] win_len(input logic [LEN_W-1:0] size,
                                          input logic [31:0] bytes);
    logic [31:0] s;
    s = {{(32-LEN_W){1'b0}}, size};
    return (s < bytes) ? s : bytes;
  endfunction

  // All n bytes starting at a lie in the window [base, base + len).
  function automatic logic ram_hit(input logic [31:0] a, input logic [31:0] base,
                                   input logic [31:0] len, input logic [2:0] n);
    logic [32:0] span;
    span = {1'b0, a - base} + 33'(n);
    return (a >= base) && (span <= {1'b0, len});
  endfunction

  // All n bytes starting at a lie in the window of len bytes ending at top.
  function automatic logic rom_hit(input logic [31:0] a, input logic [31:0] top,
                                   input logic [31:0] len, input logic [2:0] n,
                                   input logic present);
    logic [31:0] dtop;
    dtop = top - a;
    return present && (len != 32'd0) && (a <= top) && (dtop < len) &&
           (({1'b0, dtop} + 33'd1) >= 33'(n));
  endfunction

  // Number of words spanned by a block of len bytes starting at start.
  function automatic logic [LEN_W-1:0] word_count(input logic [31:0] start,
                                                   input logic [LEN_W-1:0] len);
    logic [33:0] e;
    logic [31:0] w;
    e = {2'b00, start} + 34'(len) + 34'd3;
    w = e[33:2] - {2'b00, start[31:2]};
    return (len == '0) ? '0 : w[LEN_W-1:0];
  endfunction

endpackage

FILE: rtl/core/rrmau_if.sv
// ----------------------------------------------------------------------------
// rrmau_if
// Valid/ready channels that carry requests into and results out of the unit.
// ----------------------------------------------------------------------------
interface rrmau_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  operation;
  logic [31:0] address;
  logic [31:0] write_data;
  logic [31:0] dest_address;
  logic [16:0] copy_length;

  modport source (output valid, operation, address, write_data, dest_address,
                  copy_length, input ready);
  modport sink (input valid, operation, address, write_data, dest_address,
                copy_length, output ready);
endinterface

interface rrmau_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [1:0]  violation_kind;
  logic        terminate;
  logic        is_legal;
  logic [31:0] cycles_taken;
  logic [31:0] highest_touched;

  modport source (output valid, read_data, violation_kind, terminate, is_legal,
                  cycles_taken, highest_touched, input ready);
  modport sink (input valid, read_data, violation_kind, terminate, is_legal,
                cycles_taken, highest_touched, output ready);
endinterface

FILE: rtl/core/rrmau_ram.sv
// ----------------------------------------------------------------------------
// rrmau_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module rrmau_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/rrmau_front.sv
// ----------------------------------------------------------------------------
// rrmau_front
// Accepts requests and decodes their addresses against the RAM and ROM windows.
// ----------------------------------------------------------------------------
module rrmau_front import rrmau_pkg::*; #(
  parameter int unsigned RAM_BYTES = RAM_BYTES_DEF,
  parameter int unsigned ROM_BYTES = ROM_BYTES_DEF,
  parameter logic [31:0] RAM_BASE  = RAM_BASE_DEF,
  parameter logic [31:0] ROM_TOP   = ROM_TOP_DEF
) (
  rrmau_req_if.sink  req_i,
  input  rrmau_cfg_t cfg_i,
  input  logic       hold_i,
  input  logic       full_i,
  output logic       push_o,
  output rrmau_cmd_t cmd_o
);

  logic [31:0] ram_len;
  logic [31:0] rom_len;
  logic [31:0] a;
  logic [31:0] ram_off;
  logic [31:0] rom_idx;

  assign ram_len = win_len(cfg_i.ram_size, 32'(RAM_BYTES));
  assign rom_len = win_len(cfg_i.rom_size, 32'(ROM_BYTES));
  assign a       = req_i.address;
  assign ram_off = a - RAM_BASE;
  assign rom_idx = rom_len - 32'd1 - (ROM_TOP - a);

  assign req_i.ready = !full_i && !hold_i;
  assign push_o      = req_i.valid && req_i.ready;

  always_comb begin
    cmd_o.op      = req_i.operation;
    cmd_o.addr    = a;
    cmd_o.wdata   = req_i.write_data;
    cmd_o.daddr   = req_i.dest_address;
    cmd_o.len     = req_i.copy_length;
    cmd_o.ram1    = ram_hit(a, RAM_BASE, ram_len, 3'd1);
    cmd_o.ram4    = ram_hit(a, RAM_BASE, ram_len, 3'd4);
    cmd_o.rom1    = rom_hit(a, ROM_TOP, rom_len, 3'd1, cfg_i.rom_present);
    cmd_o.rom4    = rom_hit(a, ROM_TOP, rom_len, 3'd4, cfg_i.rom_present);
    cmd_o.ram_off = ram_off[OFF_W-1:0];
    cmd_o.rom_idx = rom_idx[OFF_W-1:0];
  end

endmodule

FILE: rtl/core/rrmau_fifo.sv
// ----------------------------------------------------------------------------
// rrmau_fifo
// Two-entry queue of decoded requests between the front and back ends.
// ----------------------------------------------------------------------------
module rrmau_fifo import rrmau_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  rrmau_cmd_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output rrmau_cmd_t data_o
);

  rrmau_cmd_t entry_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = entry_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? !wptr_q : wptr_q;
    rptr_d = pop_i ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/core/rrmau_back.sv
// ----------------------------------------------------------------------------
// rrmau_back
// Executes decoded requests against byte-lane RAM and ROM stores, runs block
// copies, keeps the cycle counter and the highest touched RAM address.
// ----------------------------------------------------------------------------
module rrmau_back import rrmau_pkg::*; #(
  parameter int unsigned RAM_BYTES = RAM_BYTES_DEF,
  parameter int unsigned ROM_BYTES = ROM_BYTES_DEF,
  parameter logic [31:0] RAM_BASE  = RAM_BASE_DEF,
  parameter logic [31:0] ROM_TOP   = ROM_TOP_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rrmau_cfg_t cfg_i,
  input  logic       cmd_valid_i,
  input  rrmau_cmd_t cmd_i,
  output logic       cmd_pop_o,
  output logic       clearing_o,
  rrmau_rsp_if.source rsp_o
);

  localparam int unsigned RAM_DEPTH = (RAM_BYTES + 3) / 4;
  localparam int unsigned ROM_DEPTH = (ROM_BYTES + 3) / 4;
  localparam int unsigned RAM_RW    = $clog2(RAM_DEPTH);
  localparam int unsigned ROM_RW    = $clog2(ROM_DEPTH);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_RESULT = 3'd2;
  localparam logic [2:0] ST_CHARGE = 3'd3;
  localparam logic [2:0] ST_CPRD   = 3'd4;
  localparam logic [2:0] ST_CPWR   = 3'd5;

  // Row of byte lane k for an access whose first byte sits at offset off.
  function automatic logic [RAM_RW-1:0] ram_row(input logic [OFF_W-1:0] off,
                                                input logic [1:0] k);
    logic [OFF_W-1:0] r;
    r = (off >> 2) + OFF_W'(k < off[1:0]);
    return r[RAM_RW-1:0];
  endfunction

  function automatic logic [ROM_RW-1:0] rom_row(input logic [OFF_W-1:0] off,
                                                input logic [1:0] k);
    logic [OFF_W-1:0] r;
    r = (off >> 2) + OFF_W'(k < off[1:0]);
    return r[ROM_RW-1:0];
  endfunction

  logic [2:0]       state_q, state_d;
  rrmau_cmd_t       cur_q, cur_d;
  logic [1:0]       kind_q, kind_d;
  logic [31:0]      taken_q, taken_d;
  logic [31:0]      cycles_q, cycles_d;
  logic [31:0]      high_q, high_d;
  logic [31:0]      sp_q, sp_d;
  logic [31:0]      dp_q, dp_d;
  logic [OFF_W-1:0] idx_q, idx_d;
  logic [LEN_W-1:0] ns_q, ns_d;
  logic [LEN_W-1:0] nd_q, nd_d;
  logic             src_rom_q, src_rom_d;
  logic [1:0]       lane_q, lane_d;

  logic             o_valid_q, o_valid_d;
  logic [31:0]      o_rd_q;
  logic [1:0]       o_kind_q;
  logic             o_term_q;
  logic             o_legal_q;
  logic [31:0]      o_taken_q;
  logic [31:0]      o_high_q;
  logic             load;
  logic [31:0]      res_rd;

  logic             ram_we    [4];
  logic [RAM_RW-1:0] ram_waddr [4];
  logic [RAM_RW-1:0] ram_raddr [4];
  logic [7:0]       ram_wdata [4];
  logic [7:0]       ram_rdata [4];
  logic             ram_re;
  logic             rom_we    [4];
  logic [ROM_RW-1:0] rom_waddr [4];
  logic [ROM_RW-1:0] rom_raddr [4];
  logic [7:0]       rom_wdata [4];
  logic [7:0]       rom_rdata [4];
  logic             rom_re;

  logic [31:0]      ram_len;
  logic [31:0]      rom_len;
  logic [31:0]      s_addr, d_addr, s_off, d_off, s_ridx;
  logic             s_ram, s_rom, d_ram, d_rom;
  logic             add_s, add_d;
  logic [7:0]       cp_byte;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    rrmau_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[g]),
      .waddr_i (ram_waddr[g]),
      .wdata_i (ram_wdata[g]),
      .re_i    (ram_re),
      .raddr_i (ram_raddr[g]),
      .rdata_o (ram_rdata[g])
    );
    rrmau_ram #(.WIDTH(8), .DEPTH(ROM_DEPTH)) u_rom (
      .clk_i   (clk_i),
      .we_i    (rom_we[g]),
      .waddr_i (rom_waddr[g]),
      .wdata_i (rom_wdata[g]),
      .re_i    (rom_re),
      .raddr_i (rom_raddr[g]),
      .rdata_o (rom_rdata[g])
    );
  end

  assign ram_len = win_len(cfg_i.ram_size, 32'(RAM_BYTES));
  assign rom_len = win_len(cfg_i.rom_size, 32'(ROM_BYTES));

  // Current copy byte on each side.
  assign s_addr = cur_q.addr + 32'(idx_q[LEN_W-1:0]);
  assign d_addr = cur_q.daddr + 32'(idx_q[LEN_W-1:0]);
  assign s_off  = s_addr - RAM_BASE;
  assign d_off  = d_addr - RAM_BASE;
  assign s_ridx = rom_len - 32'd1 - (ROM_TOP - s_addr);
  assign s_ram  = ram_hit(s_addr, RAM_BASE, ram_len, 3'd1);
  assign s_rom  = rom_hit(s_addr, ROM_TOP, rom_len, 3'd1, cfg_i.rom_present);
  assign d_ram  = ram_hit(d_addr, RAM_BASE, ram_len, 3'd1);
  assign d_rom  = rom_hit(d_addr, ROM_TOP, rom_len, 3'd1, cfg_i.rom_present);
  assign add_s  = (idx_q < OFF_W'(ns_q)) && ram_hit(sp_q, RAM_BASE, ram_len, 3'd1);
  assign add_d  = (idx_q < OFF_W'(nd_q)) && ram_hit(dp_q, RAM_BASE, ram_len, 3'd1);
  assign cp_byte = src_rom_q ? rom_rdata[lane_q] : ram_rdata[lane_q];

  assign clearing_o = (state_q == ST_CLEAR);

  always_comb begin
    logic [1:0] bj;
    state_d   = state_q;
    cur_d     = cur_q;
    kind_d    = kind_q;
    taken_d   = taken_q;
    cycles_d  = cycles_q;
    high_d    = high_q;
    sp_d      = sp_q;
    dp_d      = dp_q;
    idx_d     = idx_q;
    ns_d      = ns_q;
    nd_d      = nd_q;
    src_rom_d = src_rom_q;
    lane_d    = lane_q;
    cmd_pop_o = 1'b0;
    load      = 1'b0;
    ram_re    = 1'b0;
    rom_re    = 1'b0;
    bj        = 2'd0;
    for (int k = 0; k < 4; k++) begin
      ram_we[k]    = 1'b0;
      ram_waddr[k] = '0;
      ram_wdata[k] = '0;
      ram_raddr[k] = '0;
      rom_we[k]    = 1'b0;
      rom_waddr[k] = '0;
      rom_wdata[k] = '0;
      rom_raddr[k] = '0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        for (int k = 0; k < 4; k++) begin
          ram_we[k]    = 1'b1;
          ram_waddr[k] = idx_q[RAM_RW-1:0];
        end
        if (idx_q == OFF_W'(RAM_DEPTH - 1)) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + OFF_W'(1);
        end
      end

      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          kind_d    = VIOL_NONE;
          taken_d   = '0;
          state_d   = ST_RESULT;
          unique case (cmd_i.op) inside
            OP_RDBYTE, OP_FETCH: begin
              if (cmd_i.ram1) begin
                ram_re = 1'b1;
                for (int k = 0; k < 4; k++) ram_raddr[k] = ram_row(cmd_i.ram_off, 2'(k));
                cycles_d = cycles_q + 32'd1;
                high_d   = (cmd_i.addr > high_q) ? cmd_i.addr : high_q;
              end else if (cmd_i.rom1) begin
                rom_re = 1'b1;
                for (int k = 0; k < 4; k++) rom_raddr[k] = rom_row(cmd_i.rom_idx, 2'(k));
                cycles_d = cycles_q + 32'd1;
              end else begin
                kind_d = VIOL_READ;
              end
            end
            OP_WRBYTE: begin
              if (cmd_i.ram1) begin
                for (int k = 0; k < 4; k++) begin
                  ram_we[k]    = (2'(k) == cmd_i.ram_off[1:0]);
                  ram_waddr[k] = ram_row(cmd_i.ram_off, 2'(k));
                  ram_wdata[k] = cmd_i.wdata[7:0];
                end
                cycles_d = cycles_q + 32'd1;
                high_d   = (cmd_i.addr > high_q) ? cmd_i.addr : high_q;
              end else begin
                kind_d = cmd_i.rom1 ? VIOL_ROM_WRITE : VIOL_WRITE;
              end
            end
            OP_RDWORD: begin
              if (cmd_i.ram4) begin
                ram_re = 1'b1;
                for (int k = 0; k < 4; k++) ram_raddr[k] = ram_row(cmd_i.ram_off, 2'(k));
                cycles_d = cycles_q + 32'd1;
                high_d   = (cmd_i.addr > high_q) ? cmd_i.addr : high_q;
              end else if (cmd_i.rom4) begin
                rom_re = 1'b1;
                for (int k = 0; k < 4; k++) rom_raddr[k] = rom_row(cmd_i.rom_idx, 2'(k));
                cycles_d = cycles_q + 32'd1;
              end else begin
                kind_d = VIOL_READ;
              end
            end
            OP_WRWORD: begin
              if (cmd_i.ram4) begin
                for (int k = 0; k < 4; k++) begin
                  bj           = 2'(k) - cmd_i.ram_off[1:0];
                  ram_we[k]    = 1'b1;
                  ram_waddr[k] = ram_row(cmd_i.ram_off, 2'(k));
                  ram_wdata[k] = cmd_i.wdata[8*bj +: 8];
                end
                cycles_d = cycles_q + 32'd1;
                high_d   = (cmd_i.addr > high_q) ? cmd_i.addr : high_q;
              end else begin
                kind_d = cmd_i.rom1 ? VIOL_ROM_WRITE : VIOL_WRITE;
              end
            end
            OP_COPY: begin
              ns_d    = word_count(cmd_i.addr, cmd_i.len);
              nd_d    = word_count(cmd_i.daddr, cmd_i.len);
              sp_d    = cmd_i.addr;
              dp_d    = cmd_i.daddr;
              idx_d   = '0;
              state_d = ST_CHARGE;
            end
            OP_TAKECYC: begin
              taken_d  = cycles_q;
              cycles_d = '0;
            end
            OP_ROMLOAD: begin
              if (cmd_i.addr < 32'(ROM_BYTES)) begin
                for (int k = 0; k < 4; k++) begin
                  rom_we[k]    = (2'(k) == cmd_i.addr[1:0]);
                  rom_waddr[k] = rom_row(cmd_i.addr[OFF_W-1:0], cmd_i.addr[1:0]);
                  rom_wdata[k] = cmd_i.wdata[7:0];
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      // One word of each block is charged per cycle, in full before any byte moves.
      ST_CHARGE: begin
        if (idx_q >= OFF_W'(ns_q) && idx_q >= OFF_W'(nd_q)) begin
          idx_d   = '0;
          state_d = ST_CPRD;
        end else begin
          cycles_d = cycles_q + 32'(add_s) + 32'(add_d);
          sp_d     = sp_q + 32'd4;
          dp_d     = dp_q + 32'd4;
          idx_d    = idx_q + OFF_W'(1);
        end
      end

      ST_CPRD: begin
        if (idx_q == OFF_W'(cur_q.len)) begin
          state_d = ST_RESULT;
        end else if (s_ram) begin
          ram_re = 1'b1;
          for (int k = 0; k < 4; k++) ram_raddr[k] = ram_row(s_off[OFF_W-1:0], 2'(k));
          high_d    = (s_addr > high_q) ? s_addr : high_q;
          src_rom_d = 1'b0;
          lane_d    = s_off[1:0];
          state_d   = ST_CPWR;
        end else if (s_rom) begin
          rom_re = 1'b1;
          for (int k = 0; k < 4; k++) rom_raddr[k] = rom_row(s_ridx[OFF_W-1:0], 2'(k));
          src_rom_d = 1'b1;
          lane_d    = s_ridx[1:0];
          state_d   = ST_CPWR;
        end else begin
          kind_d  = VIOL_READ;
          state_d = ST_RESULT;
        end
      end

      ST_CPWR: begin
        if (d_ram) begin
          for (int k = 0; k < 4; k++) begin
            ram_we[k]    = (2'(k) == d_off[1:0]);
            ram_waddr[k] = ram_row(d_off[OFF_W-1:0], 2'(k));
            ram_wdata[k] = cp_byte;
          end
          high_d  = (d_addr > high_q) ? d_addr : high_q;
          idx_d   = idx_q + OFF_W'(1);
          state_d = ST_CPRD;
        end else begin
          kind_d  = d_rom ? VIOL_ROM_WRITE : VIOL_WRITE;
          state_d = ST_RESULT;
        end
      end

      ST_RESULT: begin
        if (!o_valid_q || rsp_o.ready) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Read data is assembled from the lane outputs once they have settled.
  always_comb begin
    logic [1:0] ln;
    res_rd = '0;
    ln     = 2'd0;
    case (cur_q.op) inside
      OP_RDBYTE, OP_FETCH: begin
        if (cur_q.ram1) begin
          res_rd = {24'd0, ram_rdata[cur_q.ram_off[1:0]]};
        end else if (cur_q.rom1) begin
          res_rd = {24'd0, rom_rdata[cur_q.rom_idx[1:0]]};
        end
      end
      OP_RDWORD: begin
        if (cur_q.ram4) begin
          for (int j = 0; j < 4; j++) begin
            ln = cur_q.ram_off[1:0] + 2'(j);
            res_rd[8*j +: 8] = ram_rdata[ln];
          end
        end else if (cur_q.rom4) begin
          for (int j = 0; j < 4; j++) begin
            ln = cur_q.rom_idx[1:0] + 2'(j);
            res_rd[8*j +: 8] = rom_rdata[ln];
          end
        end else begin
          res_rd = BAD_WORD;
        end
      end
      default: begin
      end
    endcase
  end

  assign o_valid_d = load ? 1'b1 : (rsp_o.ready ? 1'b0 : o_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      idx_q     <= '0;
      cycles_q  <= '0;
      high_q    <= RAM_BASE;
      o_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      cycles_q  <= cycles_d;
      high_q    <= high_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    kind_q    <= kind_d;
    taken_q   <= taken_d;
    sp_q      <= sp_d;
    dp_q      <= dp_d;
    ns_q      <= ns_d;
    nd_q      <= nd_d;
    src_rom_q <= src_rom_d;
    lane_q    <= lane_d;
    if (load) begin
      o_rd_q    <= res_rd;
      o_kind_q  <= kind_q;
      o_term_q  <= (kind_q != VIOL_NONE) && cfg_i.term_en;
      o_legal_q <= (cur_q.op == OP_LEGAL) && (cur_q.ram1 || cur_q.rom1);
      o_taken_q <= taken_q;
      o_high_q  <= high_q;
    end
  end

  assign rsp_o.valid           = o_valid_q;
  assign rsp_o.read_data       = o_rd_q;
  assign rsp_o.violation_kind  = o_kind_q;
  assign rsp_o.terminate       = o_term_q;
  assign rsp_o.is_legal        = o_legal_q;
  assign rsp_o.cycles_taken    = o_taken_q;
  assign rsp_o.highest_touched = o_high_q;

endmodule

FILE: rtl/core/ram_rom_memory_access_unit.sv
// ----------------------------------------------------------------------------
// ram_rom_memory_access_unit
// A single access passes the request queue, the back end issue and the result
// register; the back end takes a new request only once the last result is
// loaded, which waits while an unaccepted result is held on the result channel.
// A block copy charges the RAM words of both blocks, then reads each byte with a
// registered read and writes it. After reset the RAM is zeroed one row of four
// bytes per cycle, and no request is accepted until that is done.
// ----------------------------------------------------------------------------
module ram_rom_memory_access_unit import rrmau_pkg::*; #(
  parameter int unsigned RAM_BYTES = RAM_BYTES_DEF,
  parameter int unsigned ROM_BYTES = ROM_BYTES_DEF,
  parameter logic [31:0] RAM_BASE  = RAM_BASE_DEF,
  parameter logic [31:0] ROM_TOP   = ROM_TOP_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rrmau_req_if.sink   req_i,
  rrmau_rsp_if.source rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rrmau_cfg_t cfg_q, cfg_d;
  logic       cfg_wr;
  logic       push, full, pop, cmd_valid, clearing;
  rrmau_cmd_t push_cmd, head_cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_RAM_SIZE:    cfg_d.ram_size    = pwdata[LEN_W-1:0];
        REG_ROM_PRESENT: cfg_d.rom_present = pwdata[0];
        REG_ROM_SIZE:    cfg_d.rom_size    = pwdata[LEN_W-1:0];
        REG_TERMINATE:   cfg_d.term_en     = pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RAM_SIZE:    prdata = 32'(cfg_q.ram_size);
      REG_ROM_PRESENT: prdata = 32'(cfg_q.rom_present);
      REG_ROM_SIZE:    prdata = 32'(cfg_q.rom_size);
      REG_TERMINATE:   prdata = 32'(cfg_q.term_en);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ram_size    <= LEN_W'(65536);
      cfg_q.rom_present <= 1'b0;
      cfg_q.rom_size    <= '0;
      cfg_q.term_en     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rrmau_front #(
    .RAM_BYTES (RAM_BYTES),
    .ROM_BYTES (ROM_BYTES),
    .RAM_BASE  (RAM_BASE),
    .ROM_TOP   (ROM_TOP)
  ) u_front (
    .req_i  (req_i),
    .cfg_i  (cfg_q),
    .hold_i (clearing),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  rrmau_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .data_o  (head_cmd)
  );

  rrmau_back #(
    .RAM_BYTES (RAM_BYTES),
    .ROM_BYTES (ROM_BYTES),
    .RAM_BASE  (RAM_BASE),
    .ROM_TOP   (ROM_TOP)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (pop),
    .clearing_o  (clearing),
    .rsp_o       (rsp_o)
  );

endmodule

FILE: rtl/core/rrmau_checker.sv
// ----------------------------------------------------------------------------
// rrmau_checker
// Port-level checks on the result channel of the RAM/ROM access unit.
// ----------------------------------------------------------------------------
module rrmau_checker import rrmau_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic [31:0] read_data_i,
  input logic [1:0]  violation_kind_i,
  input logic        terminate_i,
  input logic        is_legal_i,
  input logic [31:0] cycles_taken_i,
  input logic [31:0] highest_touched_i
);

  logic        seen_q;
  logic [31:0] last_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      last_high_q <= '0;
    end else if (valid_i && ready_i) begin
      seen_q      <= 1'b1;
      last_high_q <= highest_touched_i;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(read_data_i) &&
    $stable(violation_kind_i) && $stable(highest_touched_i))
    else $error("result changed while stalled");

  a_term_needs_viol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && terminate_i |-> violation_kind_i != VIOL_NONE)
    else $error("terminate without a violation");

  a_legal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && is_legal_i |-> violation_kind_i == VIOL_NONE &&
    cycles_taken_i == 32'd0 && read_data_i == 32'd0)
    else $error("legality answer carries other fields");

  a_bad_read_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && violation_kind_i == VIOL_READ |->
    read_data_i == 32'd0 || read_data_i == BAD_WORD)
    else $error("bad read returned unexpected data");

  a_high_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && seen_q |-> highest_touched_i >= last_high_q)
    else $error("highest touched address went down");

endmodule

bind ram_rom_memory_access_unit rrmau_checker u_rrmau_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .valid_i           (rsp_o.valid),
  .ready_i           (rsp_o.ready),
  .read_data_i       (rsp_o.read_data),
  .violation_kind_i  (rsp_o.violation_kind),
  .terminate_i       (rsp_o.terminate),
  .is_legal_i        (rsp_o.is_legal),
  .cycles_taken_i    (rsp_o.cycles_taken),
  .highest_touched_i (rsp_o.highest_touched)
);

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RAM/ROM access unit: directed and random
// requests, random stalls on both channels, results checked in order against
// a behavioral model of memory windows, cycle counter and highest address.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rrmau_pkg::*;

  localparam logic [31:0] RBASE = RAM_BASE_DEF;
  localparam logic [31:0] RTOP  = ROM_TOP_DEF;

  typedef struct packed {
    logic [31:0] rdata;
    logic [1:0]  kind;
    logic        term;
    logic        legal;
    logic [31:0] taken;
    logic [31:0] high;
  } mem_result_t;

  class mem_scoreboard;
    logic [7:0]  ram [0:65535];
    logic [7:0]  rom [0:65535];
    bit          rom_loaded [0:65535];
    logic [31:0] cyc;
    logic [31:0] high;
    logic [16:0] ram_size;
    logic        rom_en;
    logic [16:0] rom_size;
    logic        term_en;
    mem_result_t pending [$];
    int          errors;

    function void init();
      for (int i = 0; i < 65536; i++) begin
        ram[i] = 8'h00;
        rom_loaded[i] = 0;
      end
      cyc = 0;
      high = RBASE;
      ram_size = 17'd65536;
      rom_en = 0;
      rom_size = 0;
      term_en = 0;
      errors = 0;
    endfunction

    // Window sizes above the store depth are clipped to the store.
    function logic [31:0] ram_len();
      return (ram_size < 17'd65536) ? 32'(ram_size) : 32'd65536;
    endfunction

    function logic [31:0] rom_len();
      return (rom_size < 17'd65536) ? 32'(rom_size) : 32'd65536;
    endfunction

    function bit ram_in(logic [31:0] a, int n);
      logic [32:0] span;
      span = {1'b0, a - RBASE} + 33'(n);
      return a >= RBASE && span <= {1'b0, ram_len()};
    endfunction

    function bit rom_in(logic [31:0] a, int n);
      logic [31:0] d;
      d = RTOP - a;
      if (!rom_en || rom_len() == 0 || a > RTOP) return 0;
      return d < rom_len() && ({1'b0, d} + 33'd1) >= 33'(n);
    endfunction

    function int rom_at(logic [31:0] a);
      return int'(rom_len() - 32'd1 - (RTOP - a));
    endfunction

    function void bump(logic [31:0] a);
      if (a > high) high = a;
    endfunction

    function void charge(logic [31:0] start, logic [16:0] len);
      logic [33:0] e;
      logic [31:0] n;
      if (len == 0) return;
      e = {2'b00, start} + 34'(len) + 34'd3;
      n = e[33:2] - {2'b00, start[31:2]};
      for (int i = 0; i < n; i++)
        if (ram_in(start + 32'(i * 4), 1)) cyc++;
    endfunction

    function logic [1:0] copy_bytes(logic [31:0] src, logic [31:0] dst, logic [16:0] len);
      logic [7:0]  b;
      logic [31:0] s, d;
      charge(src, len);
      charge(dst, len);
      for (int i = 0; i < len; i++) begin
        s = src + 32'(i);
        d = dst + 32'(i);
        if (ram_in(s, 1)) begin
          bump(s);
          b = ram[s - RBASE];
        end else if (rom_in(s, 1)) b = rom[rom_at(s)];
        else return VIOL_READ;
        if (ram_in(d, 1)) begin
          bump(d);
          ram[d - RBASE] = b;
        end else if (rom_in(d, 1)) return VIOL_ROM_WRITE;
        else return VIOL_WRITE;
      end
      return VIOL_NONE;
    endfunction

    function void note_request(logic [3:0] op, logic [31:0] a, logic [31:0] wd,
                               logic [31:0] da, logic [16:0] len);
      mem_result_t r;
      int k;
      r = '{32'd0, VIOL_NONE, 1'b0, 1'b0, 32'd0, 32'd0};
      case (op)
        OP_RDBYTE, OP_FETCH: begin
          if (ram_in(a, 1)) begin
            cyc++; bump(a); r.rdata = ram[a - RBASE];
          end else if (rom_in(a, 1)) begin
            cyc++; r.rdata = rom[rom_at(a)];
          end else r.kind = VIOL_READ;
        end
        OP_WRBYTE: begin
          if (ram_in(a, 1)) begin
            cyc++; bump(a); ram[a - RBASE] = wd[7:0];
          end else r.kind = rom_in(a, 1) ? VIOL_ROM_WRITE : VIOL_WRITE;
        end
        OP_RDWORD: begin
          if (ram_in(a, 4)) begin
            cyc++; bump(a); k = a - RBASE;
            r.rdata = {ram[k+3], ram[k+2], ram[k+1], ram[k]};
          end else if (rom_in(a, 4)) begin
            cyc++; k = rom_at(a);
            r.rdata = {rom[k+3], rom[k+2], rom[k+1], rom[k]};
          end else begin
            r.kind = VIOL_READ; r.rdata = BAD_WORD;
          end
        end
        OP_WRWORD: begin
          if (ram_in(a, 4)) begin
            cyc++; bump(a); k = a - RBASE;
            {ram[k+3], ram[k+2], ram[k+1], ram[k]} = wd;
          end else r.kind = rom_in(a, 1) ? VIOL_ROM_WRITE : VIOL_WRITE;
        end
        OP_COPY: r.kind = copy_bytes(a, da, len);
        OP_TAKECYC: begin
          r.taken = cyc; cyc = 0;
        end
        OP_LEGAL: r.legal = ram_in(a, 1) || rom_in(a, 1);
        OP_ROMLOAD: if (a < 32'd65536) begin
          rom[a[15:0]] = wd[7:0]; rom_loaded[a[15:0]] = 1;
        end
        default: ;
      endcase
      r.term = (r.kind != VIOL_NONE) && term_en;
      r.high = high;
      pending.push_back(r);
    endfunction

    function void check_result(mem_result_t got);
      mem_result_t x;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result, nothing pending");
        return;
      end
      x = pending.pop_front();
      if (got !== x) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp rd=%h k=%0d t=%b l=%b c=%h h=%h got rd=%h k=%0d t=%b l=%b c=%h h=%h",
                   x.rdata, x.kind, x.term, x.legal, x.taken, x.high,
                   got.rdata, got.kind, got.term, got.legal, got.taken, got.high);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  rrmau_req_if req_if ();
  rrmau_rsp_if rsp_if ();

  ram_rom_memory_access_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if.sink), .rsp_o(rsp_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  mem_scoreboard board = new();
  bit rsp_quiet = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  initial begin
    req_if.valid = 0;
    req_if.operation = 0;
    req_if.address = 0;
    req_if.write_data = 0;
    req_if.dest_address = 0;
    req_if.copy_length = 0;
    rsp_if.ready = 0;
  end

  task automatic write_reg(rrmau_reg_e idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_RAM_SIZE:    board.ram_size = val[16:0];
      REG_ROM_PRESENT: board.rom_en = val[0];
      REG_ROM_SIZE:    board.rom_size = val[16:0];
      REG_TERMINATE:   board.term_en = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // The valid line is left high after an accept; it drops when a gap follows
  // or when the sender drains.
  task automatic send(logic [3:0] op, logic [31:0] a, logic [31:0] wd,
                      logic [31:0] da, logic [16:0] len);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      req_if.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1;
    req_if.operation <= op;
    req_if.address <= a;
    req_if.write_data <= wd;
    req_if.dest_address <= da;
    req_if.copy_length <= len;
    do @(posedge clk_i); while (!req_if.ready);
    board.note_request(op, a, wd, da, len);
  endtask

  // Waits for the pipeline to drain, then a margin for any trailing work.
  task automatic drain();
    req_if.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    mem_result_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.rdata = rsp_if.read_data;
      got.kind = rsp_if.violation_kind;
      got.term = rsp_if.terminate;
      got.legal = rsp_if.is_legal;
      got.taken = rsp_if.cycles_taken;
      got.high = rsp_if.highest_touched;
      board.check_result(got);
    end
  end

  // Draws a stall per result on the receiving side.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = rsp_quiet ? 0 : $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        rsp_if.ready <= 0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  // Address near an interesting edge: RAM, ROM, or anywhere.
  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return RBASE + $urandom_range(0, 300);
      4:          return RBASE + board.ram_size - $urandom_range(0, 6);
      5:          return RBASE + $urandom_range(0, 65535);
      6, 7:       return RTOP - $urandom_range(0, 300);
      8:          return RTOP - board.rom_size + $urandom_range(0, 4);
      default:    return $urandom();
    endcase
  endfunction

  // Only ROM bytes that were loaded may be read; fall back to RAM otherwise.
  function automatic bit rom_safe(logic [31:0] a, int n);
    for (int i = 0; i < n; i++)
      if (!board.ram_in(a + 32'(i), 1) && board.rom_in(a + 32'(i), 1) &&
          !board.rom_loaded[board.rom_at(a + 32'(i))]) return 0;
    return 1;
  endfunction

  task automatic random_item();
    logic [3:0]  op;
    logic [31:0] a, da;
    logic [16:0] len;
    op = 4'($urandom_range(0, 15));
    if (op > 9 && $urandom_range(0, 3) != 0) op = 4'($urandom_range(0, 8));
    a = pick_addr();
    da = pick_addr();
    len = ($urandom_range(0, 15) == 0) ? 17'($urandom_range(0, 600)) :
                                         17'($urandom_range(0, 24));
    if (op == OP_ROMLOAD)
      a = ($urandom_range(0, 7) == 0) ? $urandom() : 32'(board.rom_size) - 1 - $urandom_range(0, 300);
    if ((op == OP_RDBYTE || op == OP_FETCH) && !rom_safe(a, 1)) a = RBASE;
    if (op == OP_RDWORD && !rom_safe(a, 4)) a = RBASE;
    if (op == OP_COPY && !rom_safe(a, len)) a = RBASE + $urandom_range(0, 200);
    send(op, a, $urandom(), da, len);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    board.init();
    rst_ni <= 1;
    @(posedge clk_i);
    write_reg(REG_ROM_PRESENT, 1);
    write_reg(REG_ROM_SIZE, 512);
    write_reg(REG_TERMINATE, 1);
    write_reg(REG_RAM_SIZE, 65536);
    for (int i = 0; i < 8; i++) send(OP_ROMLOAD, 504 + i, 8'hA0 + i, 0, 0);
    send(OP_ROMLOAD, 32'hFFFF_FFFF, 32'h55, 0, 0);
    send(OP_WRWORD, RBASE, 32'hFF00_00FF, 0, 0);
    send(OP_RDWORD, RBASE, 0, 0, 0);
    send(OP_RDBYTE, RBASE + 65535, 0, 0, 0);
    send(OP_RDBYTE, RBASE + 65536, 0, 0, 0);
    send(OP_RDWORD, RBASE + 65533, 0, 0, 0);
    send(OP_WRBYTE, RBASE - 1, 32'hFFFF_FFFF, 0, 0);
    send(OP_FETCH, RTOP, 0, 0, 0);
    send(OP_RDWORD, RTOP - 3, 0, 0, 0);
    send(OP_RDWORD, RTOP - 2, 0, 0, 0);
    send(OP_WRWORD, RTOP - 1, 0, 0, 0);
    send(OP_WRBYTE, RTOP - 7, 0, 0, 0);
    send(OP_COPY, RTOP - 7, RBASE + 10, 8, 0);
    send(OP_COPY, RBASE, RBASE + 2, 32'hFFFF_FFFF, 9);
    send(OP_COPY, RBASE, RBASE + 65530, 32'hFFFF_FFFF, 12);
    send(OP_COPY, 32'hFFFF_FFFE, RBASE, 32'hFFFF_FFFF, 0);
    send(OP_LEGAL, RTOP - 512, 0, 0, 0);
    send(OP_LEGAL, RBASE, 0, 0, 0);
    send(OP_TAKECYC, 0, 0, 0, 0);
    send(OP_TAKECYC, 0, 0, 0, 0);
    send(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h1FFFF);
    drain();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: begin
          write_reg(REG_RAM_SIZE, 0);
          write_reg(REG_TERMINATE, 0);
        end
        2: begin
          write_reg(REG_RAM_SIZE, 300);
          write_reg(REG_ROM_SIZE, 65536);
        end
        3: begin
          write_reg(REG_ROM_PRESENT, 0);
          write_reg(REG_RAM_SIZE, 17'h1FFFF);
        end
        4: begin
          write_reg(REG_ROM_PRESENT, 1);
          write_reg(REG_ROM_SIZE, 0);
          write_reg(REG_TERMINATE, 1);
        end
        5: begin
          write_reg(REG_ROM_SIZE, 17'h1FFFF);
          write_reg(REG_RAM_SIZE, 65536);
        end
        default: ;
      endcase
      for (int n = 0; n < 180; n++) random_item();
      if (phase == 2) begin
        rsp_quiet = 1;
        drain();
        rsp_quiet = 0;
      end else drain();
    end
    if (board.errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #50ms;
    $display("tb_top: FAIL");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/rrmau_pkg.sv
rtl/core/rrmau_if.sv
rtl/core/rrmau_ram.sv
rtl/core/rrmau_front.sv
rtl/core/rrmau_fifo.sv
rtl/core/rrmau_back.sv
rtl/core/ram_rom_memory_access_unit.sv
rtl/core/rrmau_checker.sv
bench/tb_top.sv
